FILE: rtl/sha256_four_byte_preimage_check_assert.svh
// assertion macros for the sha-256 four-byte preimage check
// used by the rtl files that carry concurrent checks, needs a clock named aclk
`ifndef SHA256_FOUR_BYTE_PREIMAGE_CHECK_ASSERT_SVH
`define SHA256_FOUR_BYTE_PREIMAGE_CHECK_ASSERT_SVH

// checked on rising aclk, switched off while aresetn is low
`define SHA4PC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on rising aclk at every edge, reset included
`define SHA4PC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: rtl/sha4pc_pkg.sv
// shared types, constants and functions of the sha-256 four-byte preimage check
// no dependencies
`default_nettype none

package sha4pc_pkg;

    localparam int WORD_W   = 32;
    localparam int ROUNDS   = 64;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;
    localparam int NUM_REGS = 4;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        REG_TARGET_0_1 = 2'd0,
        REG_TARGET_2_3 = 2'd1,
        REG_TARGET_4_5 = 2'd2,
        REG_TARGET_6_7 = 2'd3
    } reg_idx_t;

    typedef struct packed {
        word_t        cand;
        word_t [7:0]  st;
        word_t [15:0] win;
    } stage_t;

    localparam word_t PAD_WORD = 32'h8000_0000;
    localparam word_t LEN_WORD = 32'd32;

    localparam word_t [0:7] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t [0:63] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // padded single block and initial hash for one candidate
    function automatic stage_t init_stage(input word_t cand);
        stage_t s;
        s.cand = cand;
        for (int j = 0; j < 8; j++) begin
            s.st[j] = START_HASH[j];
        end
        for (int j = 0; j < 16; j++) begin
            s.win[j] = '0;
        end
        s.win[0]  = cand;
        s.win[1]  = PAD_WORD;
        s.win[15] = LEN_WORD;
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sha4pc_round.sv
// one compression round with its message schedule step, registered
// depends on sha4pc_pkg
`default_nettype none

module sha4pc_round (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              valid_i,
    input  wire sha4pc_pkg::stage_t stage_i,
    input  wire sha4pc_pkg::word_t  k_i,
    output logic                   valid_o,
    output sha4pc_pkg::stage_t     stage_o
);

    logic               valid_reg;
    sha4pc_pkg::stage_t stage_reg;
    sha4pc_pkg::stage_t stage_next;
    sha4pc_pkg::word_t  tmp1;
    sha4pc_pkg::word_t  tmp2;
    sha4pc_pkg::word_t  choose;
    sha4pc_pkg::word_t  major;
    sha4pc_pkg::word_t  new_word;

    always_comb begin
        choose = (stage_i.st[4] & stage_i.st[5]) ^ (~stage_i.st[4] & stage_i.st[6]);
        major  = (stage_i.st[0] & stage_i.st[1]) ^ (stage_i.st[0] & stage_i.st[2])
               ^ (stage_i.st[1] & stage_i.st[2]);
        tmp1   = stage_i.st[7] + sha4pc_pkg::big_sigma1(stage_i.st[4]) + choose
               + k_i + stage_i.win[0];
        tmp2   = sha4pc_pkg::big_sigma0(stage_i.st[0]) + major;

        new_word = stage_i.win[0] + sha4pc_pkg::small_sigma0(stage_i.win[1])
                 + stage_i.win[9] + sha4pc_pkg::small_sigma1(stage_i.win[14]);

        stage_next.cand  = stage_i.cand;
        stage_next.st[7] = stage_i.st[6];
        stage_next.st[6] = stage_i.st[5];
        stage_next.st[5] = stage_i.st[4];
        stage_next.st[4] = stage_i.st[3] + tmp1;
        stage_next.st[3] = stage_i.st[2];
        stage_next.st[2] = stage_i.st[1];
        stage_next.st[1] = stage_i.st[0];
        stage_next.st[0] = tmp1 + tmp2;
        for (int j = 0; j < 15; j++) begin
            stage_next.win[j] = stage_i.win[j+1];
        end
        stage_next.win[15] = new_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign valid_o = valid_reg;
    assign stage_o = stage_reg;

endmodule

`default_nettype wire

FILE: rtl/sha4pc_final.sv
// final hash addition, target compare and result register
// depends on sha4pc_pkg
`default_nettype none

module sha4pc_final (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    valid_i,
    input  wire sha4pc_pkg::stage_t      stage_i,
    input  wire sha4pc_pkg::word_t [7:0] target_i,
    output logic                         valid_o,
    output logic                         matched_o,
    output sha4pc_pkg::word_t            cand_o,
    output sha4pc_pkg::word_t [7:0]      digest_o
);

    logic                    valid_reg;
    logic                    matched_reg;
    logic                    matched_next;
    sha4pc_pkg::word_t       cand_reg;
    sha4pc_pkg::word_t [7:0] digest_reg;
    sha4pc_pkg::word_t [7:0] digest_next;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            digest_next[j] = stage_i.st[j] + sha4pc_pkg::START_HASH[j];
        end
        matched_next = (digest_next == target_i);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            matched_reg <= matched_next;
            cand_reg    <= stage_i.cand;
            digest_reg  <= digest_next;
        end
    end

    assign valid_o   = valid_reg;
    assign matched_o = matched_reg;
    assign cand_o    = cand_reg;
    assign digest_o  = digest_reg;

endmodule

`default_nettype wire

FILE: rtl/sha256_four_byte_preimage_check.sv
// Hashes one 32-bit candidate per transfer with SHA-256 (single padded block) and flags a
// match against a 256-bit target set over APB. Fully pipelined: an entry register, one
// register stage per round (64) and a final add/compare stage, so a new candidate is taken
// every cycle unless the result side stalls. A stall on the result side freezes the whole
// pipeline; a one-entry input skid register still takes one transfer during it. Targets
// (64-bit registers at byte addresses 0, 8, 16, 24, each holding two digest words, the
// lower-numbered one in the high half) should only be written while no candidate is in
// flight.
`default_nettype none

`include "sha256_four_byte_preimage_check_assert.svh"

module sha256_four_byte_preimage_check (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // candidate_word
    input  wire logic [31:0]                   s_tdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // candidate_echo, digest_words_0_1, digest_words_2_3, digest_words_4_5, digest_words_6_7
    output logic [287:0]                       m_tdata,
    // matched
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sha4pc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sha4pc_pkg::DATA_W-1:0] pwdata,
    output logic [sha4pc_pkg::DATA_W-1:0]      prdata,
    output logic                               pready
);

    localparam int N = sha4pc_pkg::ROUNDS;

    logic                          advance;
    logic                          in_xfer;
    logic                          cfg_write;
    sha4pc_pkg::reg_idx_t          cfg_idx;
    logic                          skid_valid_reg;
    sha4pc_pkg::word_t             skid_data_reg;
    logic                          entry_valid_next;
    sha4pc_pkg::word_t             entry_cand;
    logic [N:0]                    pipe_valid;
    sha4pc_pkg::stage_t            pipe_stage [0:N];
    logic                          entry_valid_reg;
    sha4pc_pkg::stage_t            entry_stage_reg;
    logic [sha4pc_pkg::DATA_W-1:0] target_reg [0:sha4pc_pkg::NUM_REGS-1];
    sha4pc_pkg::word_t [7:0]       target_words;
    sha4pc_pkg::word_t             res_cand;
    sha4pc_pkg::word_t [7:0]       res_digest;
    logic                          res_matched;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;

    assign entry_valid_next = skid_valid_reg || in_xfer;
    assign entry_cand       = skid_valid_reg ? skid_data_reg : s_tdata;

    // skid holds a transfer taken while the pipeline is frozen
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (advance) begin
            skid_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!advance && in_xfer) begin
            skid_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else if (advance) begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_stage_reg <= sha4pc_pkg::init_stage(entry_cand);
        end
    end

    assign pipe_valid[0] = entry_valid_reg;
    assign pipe_stage[0] = entry_stage_reg;

    for (genvar i = 0; i < N; i++) begin : g_round
        sha4pc_round u_round (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .valid_i (pipe_valid[i]),
            .stage_i (pipe_stage[i]),
            .k_i     (sha4pc_pkg::ROUND_K[i]),
            .valid_o (pipe_valid[i+1]),
            .stage_o (pipe_stage[i+1])
        );
    end

    for (genvar p = 0; p < sha4pc_pkg::NUM_REGS; p++) begin : g_target
        assign target_words[2*p]   = target_reg[p][63:32];
        assign target_words[2*p+1] = target_reg[p][31:0];
    end

    sha4pc_final u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .valid_i   (pipe_valid[N]),
        .stage_i   (pipe_stage[N]),
        .target_i  (target_words),
        .valid_o   (m_tvalid),
        .matched_o (res_matched),
        .cand_o    (res_cand),
        .digest_o  (res_digest)
    );

    assign m_tdata = {res_digest[6], res_digest[7], res_digest[4], res_digest[5],
                      res_digest[2], res_digest[3], res_digest[0], res_digest[1], res_cand};
    assign m_tuser = res_matched;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = sha4pc_pkg::reg_idx_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < sha4pc_pkg::NUM_REGS; r++) begin
                target_reg[r] <= '0;
            end
        end else if (cfg_write) begin
            unique case (cfg_idx)
                sha4pc_pkg::REG_TARGET_0_1: target_reg[0] <= pwdata;
                sha4pc_pkg::REG_TARGET_2_3: target_reg[1] <= pwdata;
                sha4pc_pkg::REG_TARGET_4_5: target_reg[2] <= pwdata;
                sha4pc_pkg::REG_TARGET_6_7: target_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            sha4pc_pkg::REG_TARGET_0_1: prdata = target_reg[0];
            sha4pc_pkg::REG_TARGET_2_3: prdata = target_reg[1];
            sha4pc_pkg::REG_TARGET_4_5: prdata = target_reg[2];
            sha4pc_pkg::REG_TARGET_6_7: prdata = target_reg[3];
            default:                    prdata = '0;
        endcase
    end

    `SHA4PC_ASSERT(a_skid_kept, skid_valid_reg && !advance |=> skid_valid_reg, "skid entry lost")
    `SHA4PC_ASSERT(a_skid_drain, skid_valid_reg && advance |=> pipe_valid[0], "skid not drained")
    `SHA4PC_ASSERT(a_stall_fill, in_xfer && !advance |=> skid_valid_reg, "stalled transfer dropped")
    `SHA4PC_ASSERT(a_stall_hold, !advance |=> $stable(pipe_valid), "pipeline moved during stall")
    `SHA4PC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !skid_valid_reg && !m_tvalid, "not empty after reset")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench for sha256_four_byte_preimage_check
// streams candidates through the hash pipeline and checks digests and match flags
// depends on sha4pc_pkg and the rtl top level
`default_nettype none

module tb_top;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [0:7][31:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] RK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef logic [3:0][63:0] digest_pairs_t;

    typedef struct packed {
        sha4pc_pkg::word_t cand;
        logic              matched;
        digest_pairs_t     pairs;
    } hash_result_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [31:0]                   s_tdata  = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [287:0]                  m_tdata;
    logic                          m_tuser;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [sha4pc_pkg::ADDR_W-1:0] paddr    = '0;
    logic [sha4pc_pkg::DATA_W-1:0] pwdata   = '0;
    logic [sha4pc_pkg::DATA_W-1:0] prdata;
    logic                          pready;

    logic [63:0]                   target_regs [sha4pc_pkg::NUM_REGS];
    sha4pc_pkg::word_t             pending_candidates [$];
    hash_result_t                  expected_hashes [$];
    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;
    bit                            send_hold     = 1'b0;
    int                            error_count   = 0;
    int                            cycle_count   = 0;

    sha256_four_byte_preimage_check i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic sha4pc_pkg::word_t ror(input sha4pc_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // single padded block of a four-byte message, 64 rounds plus feed-forward
    function automatic digest_pairs_t digest_of(input sha4pc_pkg::word_t msg);
        sha4pc_pkg::word_t sched [64];
        sha4pc_pkg::word_t v [8];
        sha4pc_pkg::word_t t1;
        sha4pc_pkg::word_t t2;
        digest_pairs_t     d;
        for (int i = 0; i < 16; i++) begin
            sched[i] = '0;
        end
        sched[0]  = msg;
        sched[1]  = 32'h8000_0000;
        sched[15] = 32'd32;
        for (int i = 16; i < 64; i++) begin
            sched[i] = sched[i-16] + sched[i-7]
                     + (ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3))
                     + (ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = IV[i];
        end
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + sched[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int k = 0; k < 4; k++) begin
            d[k] = {v[2*k] + IV[2*k], v[2*k+1] + IV[2*k+1]};
        end
        return d;
    endfunction

    function automatic hash_result_t predict_hash(input sha4pc_pkg::word_t cand);
        hash_result_t r;
        r.cand    = cand;
        r.pairs   = digest_of(cand);
        r.matched = 1'b1;
        for (int k = 0; k < sha4pc_pkg::NUM_REGS; k++) begin
            if (r.pairs[k] != target_regs[k]) begin
                r.matched = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic sha4pc_pkg::word_t random_candidate();
        sha4pc_pkg::word_t c;
        case ($urandom_range(3))
            0: c = $urandom();
            1: c = $urandom_range(255);
            2: c = ~sha4pc_pkg::word_t'($urandom_range(255));
            default: c = sha4pc_pkg::word_t'(1) << $urandom_range(31);
        endcase
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    task automatic apb_access(input sha4pc_pkg::reg_idx_t r, input bit wr,
                              input logic [63:0] wval, output logic [63:0] rval);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 3'b000};
        pwdata  <= wval;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        rval    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_targets();
        sha4pc_pkg::reg_idx_t r;
        logic [63:0]          rv;
        r = r.first();
        repeat (sha4pc_pkg::NUM_REGS) begin
            apb_access(r, 1'b0, '0, rv);
            if (rv !== target_regs[r]) begin
                report_mismatch($sformatf("register readback %s", r.name()), rv,
                                target_regs[r]);
            end
            r = r.next();
        end
    endtask

    task automatic program_targets(input digest_pairs_t tgt);
        sha4pc_pkg::reg_idx_t r;
        logic [63:0]          rv;
        r = r.first();
        repeat (sha4pc_pkg::NUM_REGS) begin
            apb_access(r, 1'b1, tgt[r], rv);
            target_regs[r] = tgt[r];
            r = r.next();
        end
        check_targets();
    endtask

    task automatic queue_candidates(input sha4pc_pkg::word_t hit, input int hit_pct,
                                    input int n);
        repeat (n) begin
            if ($urandom_range(99) < hit_pct) begin
                pending_candidates.push_back(hit);
            end else begin
                pending_candidates.push_back(random_candidate());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_candidates.size() > 0 || s_tvalid || expected_hashes.size() > 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // near miss: target is the digest of hit with one bit flipped in one register
    task automatic run_near_miss(input int k, input int n);
        sha4pc_pkg::word_t hit;
        digest_pairs_t     tgt;
        hit    = $urandom();
        tgt    = digest_of(hit);
        tgt[k] = tgt[k] ^ (64'd1 << $urandom_range(63));
        program_targets(tgt);
        queue_candidates(hit, 30, n);
        wait_drained();
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input side driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_hashes.push_back(predict_hash(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_candidates.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= pending_candidates.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side monitor
    always @(posedge aclk) begin : result_monitor
        hash_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("unexpected result transfer", {32'd0, m_tdata[31:0]}, '0);
                end else begin
                    want = expected_hashes.pop_front();
                    if (m_tdata[31:0] !== want.cand) begin
                        report_mismatch("candidate_echo", {32'd0, m_tdata[31:0]},
                                        {32'd0, want.cand});
                    end
                    if (m_tuser !== want.matched) begin
                        report_mismatch($sformatf("matched for %h", want.cand),
                                        {63'd0, m_tuser}, {63'd0, want.matched});
                    end
                    for (int k = 0; k < 4; k++) begin
                        if (m_tdata[32+64*k +: 64] !== want.pairs[k]) begin
                            report_mismatch($sformatf("digest pair %0d for %h", k, want.cand),
                                            m_tdata[32+64*k +: 64], want.pairs[k]);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        digest_pairs_t     tgt;
        sha4pc_pkg::word_t hit;
        for (int k = 0; k < sha4pc_pkg::NUM_REGS; k++) begin
            target_regs[k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 6;
        recv_idle_pct = 56;

        // reset values, then directed candidates against the all-zero target
        check_targets();
        pending_candidates.push_back(32'h0000_0000);
        pending_candidates.push_back(32'hffff_ffff);
        pending_candidates.push_back(32'h8000_0000);
        pending_candidates.push_back(32'h0000_0001);
        pending_candidates.push_back(32'h7fff_ffff);
        pending_candidates.push_back(32'hffff_fffe);
        pending_candidates.push_back(32'h6162_6364);
        pending_candidates.push_back(32'h5555_5555);
        pending_candidates.push_back(32'haaaa_aaaa);
        pending_candidates.push_back(32'h0000_0080);
        wait_drained();

        // directed hit, a miss right after it, then the hit again
        hit = 32'h6162_6364;
        program_targets(digest_of(hit));
        pending_candidates.push_back(hit);
        pending_candidates.push_back(32'h6162_6365);
        pending_candidates.push_back(hit);
        wait_drained();

        // full match on a random candidate
        hit = $urandom();
        program_targets(digest_of(hit));
        queue_candidates(hit, 10, 350);
        wait_drained();
        run_near_miss(0, 60);

        send_idle_pct = 56;
        recv_idle_pct = 6;
        run_near_miss(1, 60);

        // all-ones target, with one full drain in the middle of the stream
        program_targets({4{64'hffff_ffff_ffff_ffff}});
        queue_candidates(32'hffff_ffff, 5, 300);
        while (pending_candidates.size() > 150) begin
            @(negedge aclk);
        end
        send_hold = 1'b1;
        @(negedge aclk);
        while (s_tvalid || expected_hashes.size() > 0) begin
            @(negedge aclk);
        end
        send_hold = 1'b0;
        wait_drained();
        run_near_miss(2, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_near_miss(3, 60);

        // target taken from the lowest candidate
        tgt = digest_of(32'h0000_0000);
        program_targets(tgt);
        queue_candidates(32'h0000_0000, 10, 350);
        wait_drained();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
